@@ rtl/fsmm_pkg.sv @@
// ----------------------------------------------------------------------------
// fsmm_pkg
// shared constants and binary64 helpers for the sum/min/max aggregator
// ----------------------------------------------------------------------------
package fsmm_pkg;

    localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] POS_ZERO     = 64'h0;

    function automatic logic f_is_nan(input logic [63:0] b);
        return b[62:0] > POS_INF_BITS[62:0];
    endfunction

    // strict a < b, neither is NaN; signed zeros compare equal
    function automatic logic f_less(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (both_zero)
            return 1'b0;
        if (a[63] != b[63])
            return a[63];
        if (a[63])
            return a[62:0] > b[62:0];
        return a[62:0] < b[62:0];
    endfunction

endpackage

@@ rtl/fsmm_add.sv @@
// ----------------------------------------------------------------------------
// fsmm_add
// combinational binary64 adder, round to nearest even, canonical NaN out
// ----------------------------------------------------------------------------
module fsmm_add (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_sum
);
    import fsmm_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swap;
    logic [63:0] big, sml;
    logic [10:0] eb, es;
    logic [52:0] mb, ms;
    logic [11:0] ed;
    logic [55:0] mb_x, ms_x;   // mantissa with guard, round, sticky
    logic [55:0] ms_sh;
    logic        sticky;
    logic [56:0] raw;
    logic        sub;
    logic [5:0]  lz;
    logic [56:0] norm;
    logic [12:0] e_n;
    logic [52:0] mant;
    logic        rnd_up;
    logic [53:0] mant_r;
    logic [12:0] e_r;
    logic        sgn;
    logic [55:0] lost_mask;
    logic [12:0] shl;

    always_comb begin
        a_nan  = f_is_nan(i_a);
        b_nan  = f_is_nan(i_b);
        a_inf  = (i_a[62:0] == POS_INF_BITS[62:0]);
        b_inf  = (i_b[62:0] == POS_INF_BITS[62:0]);
        swap   = i_b[62:0] > i_a[62:0];
        big    = swap ? i_b : i_a;
        sml    = swap ? i_a : i_b;
        eb     = big[62:52];
        es     = sml[62:52];
        mb     = {(eb != 11'd0), big[51:0]};
        ms     = {(es != 11'd0), sml[51:0]};
        ed     = {1'b0, (eb == 11'd0) ? 11'd1 : eb} - {1'b0, (es == 11'd0) ? 11'd1 : es};
        mb_x   = {mb, 3'b000};
        ms_x   = {ms, 3'b000};
        lost_mask = 56'd0;
        if (ed > 12'd55) begin
            ms_sh  = 56'd0;
            sticky = (ms != 53'd0);
        end else begin
            lost_mask = (56'd1 << ed[5:0]) - 56'd1;
            ms_sh  = ms_x >> ed[5:0];
            sticky = |(ms_x & lost_mask);
        end
        ms_sh[0] = ms_sh[0] | sticky;
        sub    = big[63] ^ sml[63];
        raw    = sub ? ({1'b0, mb_x} - {1'b0, ms_sh}) : ({1'b0, mb_x} + {1'b0, ms_sh});
        // leading zero count
        lz = 6'd57;
        for (int k = 0; k < 57; k++) begin
            if (raw[k])
                lz = 6'(56 - k);
        end
        e_n  = {2'b00, (eb == 11'd0) ? 11'd1 : eb} + 13'd1;
        norm = raw;
        if (raw != 57'd0) begin
            // shift left so msb sits at bit 56, but not below exponent 1
            if ({7'd0, lz} >= e_n) begin
                shl  = e_n - 13'd1;
                e_n  = 13'd0;
            end else begin
                shl  = {7'd0, lz};
                e_n  = e_n - {7'd0, lz};
            end
            norm = raw << shl[5:0];
        end else begin
            shl = 13'd0;
        end
        // norm[56:4] mantissa, norm[3] guard, norm[2:0] sticky
        mant   = norm[56:4];
        rnd_up = norm[3] & ((|norm[2:0]) | norm[4]);
        mant_r = {1'b0, mant} + {53'd0, rnd_up};
        e_r    = e_n;
        if (mant_r[53]) begin
            mant_r = mant_r >> 1;
            e_r    = e_r + 13'd1;
        end else if (e_r == 13'd0 && mant_r[52]) begin
            e_r = 13'd1;
        end
        sgn = big[63];
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[63] != i_b[63])))
            o_sum = QNAN_BITS;
        else if (a_inf)
            o_sum = i_a;
        else if (b_inf)
            o_sum = i_b;
        else if (raw == 57'd0)
            o_sum = {(i_a[63] & i_b[63]), 63'd0};
        else if (e_r >= 13'd2047)
            o_sum = {sgn, POS_INF_BITS[62:0]};
        else
            o_sum = {sgn, e_r[10:0], mant_r[51:0]};
    end

endmodule

@@ rtl/fp64_sum_min_max_aggregator.sv @@
// ----------------------------------------------------------------------------
// fp64_sum_min_max_aggregator
// streaming binary64 sum, minimum and maximum over sets of samples
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | i_valid / o_ready  | i_value_bits, i_is_last, i_no_sample
//  output   | o_valid / i_ready  | o_sum_bits, o_min_bits, o_max_bits, o_empty_res
//
//  one item per cycle while o_ready is high; the add and both compares sit between the accumulators
//  and the result register, so a result shows in the cycle after the last item is taken.
//  input is taken whenever the result register is empty or being drained.
//  reset (synchronous) clears accumulators to +0, +inf, -inf and the flags.
// ----------------------------------------------------------------------------
module fp64_sum_min_max_aggregator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value_bits,
    input  logic        i_is_last,
    input  logic        i_no_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_sum_bits,
    output logic [63:0] o_min_bits,
    output logic [63:0] o_max_bits,
    output logic        o_empty_res
);
    import fsmm_pkg::*;

    logic [63:0] r_sum, r_min, r_max, n_sum, n_min, n_max;
    logic        r_seen_real, r_seen_any, n_seen_real, n_seen_any;
    logic        r_out_valid;
    logic [63:0] add_out;
    logic        take, v_nan;

    fsmm_add u_add (.i_a(r_sum), .i_b(i_value_bits), .o_sum(add_out));

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        v_nan       = f_is_nan(i_value_bits);
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_seen_real = r_seen_real;
        n_seen_any  = r_seen_any;
        if (!i_no_sample) begin
            n_sum      = add_out;
            n_seen_any = 1'b1;
            if (!v_nan) begin
                n_seen_real = 1'b1;
                if (!r_seen_real || f_less(i_value_bits, r_min))
                    n_min = i_value_bits;
                if (!r_seen_real || f_less(r_max, i_value_bits))
                    n_max = i_value_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= POS_ZERO;
            r_min       <= POS_INF_BITS;
            r_max       <= NEG_INF_BITS;
            r_seen_real <= 1'b0;
            r_seen_any  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_is_last)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            if (take) begin
                if (i_is_last) begin
                    r_sum       <= POS_ZERO;
                    r_min       <= POS_INF_BITS;
                    r_max       <= NEG_INF_BITS;
                    r_seen_real <= 1'b0;
                    r_seen_any  <= 1'b0;
                end else begin
                    r_sum       <= n_sum;
                    r_min       <= n_min;
                    r_max       <= n_max;
                    r_seen_real <= n_seen_real;
                    r_seen_any  <= n_seen_any;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take && i_is_last) begin
            o_sum_bits  <= n_seen_any ? n_sum : POS_ZERO;
            o_min_bits  <= n_seen_real ? n_min : QNAN_BITS;
            o_max_bits  <= n_seen_real ? n_max : QNAN_BITS;
            o_empty_res <= !n_seen_any;
        end
    end

    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_is_last |=> !r_seen_any && !r_seen_real)
        else $error("accumulators not cleared after closing transfer");
    a_real_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_real |-> r_seen_any)
        else $error("real sample flag without any sample");
    a_empty_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_min_bits == QNAN_BITS && o_sum_bits == POS_ZERO)
        else $error("empty set result malformed");
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_real |-> !f_less(r_max, r_min))
        else $error("minimum above maximum");

endmodule

@@ tb/fp64_sum_min_max_aggregator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp64_sum_min_max_aggregator_tb
// checks the binary64 sum/min/max reduction against a behavioral predictor
// built on native double arithmetic; directed corner sets, then random sets
// under three idle/stall mixes on the input and result channels
// ----------------------------------------------------------------------------
module fp64_sum_min_max_aggregator_tb;
    import fsmm_pkg::*;

    localparam int N_RANDOM = 1800;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
        logic        no_sample;
    } sample_t;

    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] min;
        logic [63:0] max;
        logic        empty;
    } summary_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_value_bits = '0;
    logic        i_is_last = 1'b0;
    logic        i_no_sample = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_sum_bits;
    logic [63:0] o_min_bits;
    logic [63:0] o_max_bits;
    logic        o_empty_res;

    fp64_sum_min_max_aggregator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value_bits (i_value_bits),
        .i_is_last    (i_is_last),
        .i_no_sample  (i_no_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sum_bits   (o_sum_bits),
        .o_min_bits   (o_min_bits),
        .o_max_bits   (o_max_bits),
        .o_empty_res  (o_empty_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sample_t  pending_q[$];
    summary_t summary_q[$];
    int       n_total;
    int       n_sent;
    int       n_sets;
    int       n_checked;
    int       n_errors;

    // running accumulators of the predictor
    logic [63:0] acc_sum;
    logic [63:0] acc_min;
    logic [63:0] acc_max;
    logic        acc_real;
    logic        acc_any;

    function automatic logic is_nan64(logic [63:0] b);
        return b[62:0] > 63'h7FF0_0000_0000_0000;
    endfunction

    function automatic void clear_set();
        acc_sum  = POS_ZERO;
        acc_min  = POS_INF_BITS;
        acc_max  = NEG_INF_BITS;
        acc_real = 1'b0;
        acc_any  = 1'b0;
    endfunction

    function automatic void absorb_sample(sample_t s);
        logic [63:0] nsum;
        summary_t    r;
        if (!s.no_sample) begin
            nsum = $realtobits($bitstoreal(acc_sum) + $bitstoreal(s.value));
            acc_sum = is_nan64(nsum) ? QNAN_BITS : nsum;
            acc_any = 1'b1;
            if (!is_nan64(s.value)) begin
                if (!acc_real) begin
                    acc_min  = s.value;
                    acc_max  = s.value;
                    acc_real = 1'b1;
                end else begin
                    if ($bitstoreal(s.value) < $bitstoreal(acc_min)) acc_min = s.value;
                    if ($bitstoreal(s.value) > $bitstoreal(acc_max)) acc_max = s.value;
                end
            end
        end
        if (s.last) begin
            r.sum   = acc_any ? acc_sum : POS_ZERO;
            r.min   = acc_real ? acc_min : QNAN_BITS;
            r.max   = acc_real ? acc_max : QNAN_BITS;
            r.empty = !acc_any;
            summary_q.push_back(r);
            clear_set();
        end
    endfunction

    function automatic logic [63:0] rand_value(logic [63:0] prev);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v[62:52] = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
            4: ;
            5: case ($urandom_range(0, 5))
                   0: v = POS_ZERO;
                   1: v = 64'h8000_0000_0000_0000;
                   2: v = POS_INF_BITS;
                   3: v = NEG_INF_BITS;
                   4: v = 64'h7FEF_FFFF_FFFF_FFFF;
                   default: v = 64'hFFEF_FFFF_FFFF_FFFF;
               endcase
            6: v[62:52] = 11'd0;
            7: begin
                v[62:52] = 11'h7FF;
                if (v[51:0] == 52'd0) v[0] = 1'b1;
            end
            8: v[62:52] = 11'h7FE - 11'($urandom_range(0, 3));
            default: v = {~prev[63], prev[62:0]};
        endcase
        return v;
    endfunction

    function automatic void add_item(logic [63:0] v, logic last, logic ns);
        sample_t s;
        s.value = v;
        s.last = last;
        s.no_sample = ns;
        pending_q.push_back(s);
        if (last) n_sets++;
    endfunction

    // idle percentages per third of the run: sender, then receiver
    function automatic int phase_of();
        return (n_total == 0) ? 0 : (n_sent * 3) / n_total;
    endfunction

    // driver
    always @(posedge i_clk) begin
        int send_idle;
        if (i_rst_n) begin
            if (i_valid && o_ready) absorb_sample({i_value_bits, i_is_last, i_no_sample});
            if (!i_valid || o_ready) begin
                send_idle = (phase_of() == 0) ? 9 : (phase_of() == 1) ? 57 : 0;
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    sample_t s;
                    s = pending_q.pop_front();
                    i_valid      <= 1'b1;
                    i_value_bits <= s.value;
                    i_is_last    <= s.last;
                    i_no_sample  <= s.no_sample;
                    n_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge i_clk) begin
        int stall;
        summary_t e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (summary_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_errors++;
                end else begin
                    e = summary_q.pop_front();
                    n_checked++;
                    if (o_sum_bits !== e.sum) begin
                        $error("sum_bits: expected %h, got %h", e.sum, o_sum_bits);
                        n_errors++;
                    end
                    if (o_min_bits !== e.min) begin
                        $error("min_bits: expected %h, got %h", e.min, o_min_bits);
                        n_errors++;
                    end
                    if (o_max_bits !== e.max) begin
                        $error("max_bits: expected %h, got %h", e.max, o_max_bits);
                        n_errors++;
                    end
                    if (o_empty_res !== e.empty) begin
                        $error("empty_res: expected %b, got %b", e.empty, o_empty_res);
                        n_errors++;
                    end
                end
            end
            stall = (phase_of() == 0) ? 57 : (phase_of() == 1) ? 9 : 0;
            i_ready <= ($urandom_range(0, 99) >= stall);
        end
    end

    initial begin
        logic [63:0] prev;
        int          len;
        n_sent = 0;
        n_sets = 0;
        n_checked = 0;
        n_errors = 0;
        n_total = 0;
        clear_set();

        // empty set, then a set of NaNs only
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        add_item(64'h7FF0_0000_0000_0001, 1'b0, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        // signed zero ties, both orders
        add_item(64'h0, 1'b0, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        add_item(64'h0, 1'b1, 1'b0);
        // inf minus inf, and overflow to inf
        add_item(POS_INF_BITS, 1'b0, 1'b0);
        add_item(NEG_INF_BITS, 1'b1, 1'b0);
        add_item(64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        add_item(64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        // subnormals, with a NaN in the middle and a skipped slot
        add_item(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        add_item(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
        add_item(64'hDEAD_BEEF_0000_0000, 1'b0, 1'b1);
        add_item(64'h800F_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        // skipped last slot closes a non-empty set
        add_item(64'h3FF0_0000_0000_0000, 1'b0, 1'b0);
        add_item(64'hC000_0000_0000_0000, 1'b0, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        // equal values: earlier kept
        add_item(64'h4000_0000_0000_0000, 1'b0, 1'b0);
        add_item(64'h4000_0000_0000_0000, 1'b1, 1'b0);

        prev = 64'h3FF0_0000_0000_0000;
        while (pending_q.size() < N_RANDOM + 20) begin
            len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                prev = rand_value(prev);
                add_item(prev, 1'b0, $urandom_range(0, 15) == 0);
            end
            add_item(rand_value(prev), 1'b1, len == 0 || $urandom_range(0, 9) == 0);
        end
        n_total = pending_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (i_valid || summary_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d items in %0d sets sent, %0d results checked", n_total, n_sets, n_checked);
        if (n_errors == 0 && summary_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
